>>> src/stereo_bit_crusher_core_macros.svh
// ----------------------------------------------------------------------------
// stereo_bit_crusher_core_macros.svh
// Assertion helpers for the stereo bit crusher; all sample on clock and are
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STEREO_BIT_CRUSHER_CORE_MACROS_SVH
`define STEREO_BIT_CRUSHER_CORE_MACROS_SVH

// property must hold on every clock edge outside reset
`define SBC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// consequent must hold on the clock edge after the antecedent
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, register codes and the tanh table generator of the stereo
// bit crusher.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int PROD_W       = SAMPLE_WIDTH + 13;   // sample x signed drive
   localparam int MAG_W        = SAMPLE_WIDTH + 12;
   localparam int TANH_SHIFT   = SAMPLE_WIDTH + 10;   // Q5.23 -> table step of 8
   localparam int BLEND_W      = SAMPLE_WIDTH + 10;

   localparam logic signed [SAMPLE_WIDTH-1:0] FULL_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] FULL_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // register indexes
   localparam logic [1:0] CSR_BIT_DEPTH     = 2'd0;
   localparam logic [1:0] CSR_HOLD_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_MIX_AMOUNT    = 2'd2;
   localparam logic [1:0] CSR_DRIVE_GAIN    = 2'd3;

   localparam logic [4:0]  RST_BIT_DEPTH     = 5'd8;
   localparam logic [6:0]  RST_HOLD_INTERVAL = 7'd2;
   localparam logic [8:0]  RST_MIX_AMOUNT    = 9'd256;
   localparam logic [11:0] RST_DRIVE_GAIN    = 12'd256;
   localparam logic [11:0] DRIVE_UNITY       = 12'd256;
   localparam logic [8:0]  MIX_FULL          = 9'd256;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_in;
      logic signed [SAMPLE_WIDTH-1:0] right_in;
      logic                           last_frame;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
      logic                           frame_end;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  bit_depth;
      logic [8:0]  mix_amount;
      logic [11:0] drive_gain;
   } cfg_type;

   // per-step strobes from the sequencer to both lanes
   typedef struct packed {
      logic load;
      logic shape;
      logic quant;
      logic capture;
      logic prod;
   } lane_ctl_type;

   localparam logic [63:0] FX_ONE = 64'd1 << 30;

   // shift-subtract divide, evaluated at elaboration only
   function automatic logic [63:0] sbc_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-a) in Q2.30 by a series through the 16th power of a
   function automatic logic [63:0] sbc_exp_neg(input logic [63:0] a);
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      pos  = FX_ONE;
      neg  = '0;
      term = FX_ONE;
      for (int n = 1; n <= 16; n++) begin
         term = sbc_udiv((term * a) >> 30, 64'(n));
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      return pos - neg;
   endfunction

   // entry k of the tanh table: tanh(8k/depth), Q1.15, capped at full scale
   function automatic logic [SAMPLE_WIDTH-1:0] sbc_tanh_entry(input int k, input int depth);
      logic [63:0] r;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] v;
      r = sbc_exp_neg(sbc_udiv(64'd16 << 30, 64'(depth)));
      e = FX_ONE;
      for (int j = 0; j < k; j++) begin
         e = (e * r + (FX_ONE >> 1)) >> 30;
         if (e > FX_ONE) e = FX_ONE;
      end
      num = (FX_ONE - e) << (SAMPLE_WIDTH - 1);
      den = FX_ONE + e;
      v   = sbc_udiv(num + (den >> 1), den);
      if (v > 64'(FULL_POS)) v = 64'(FULL_POS);
      return v[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

>>> src/sbc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_lane
// One channel: drive multiply, tanh shaping, sample hold, quantize and
// dry/wet blend, one registered step per strobe.
// ----------------------------------------------------------------------------
module sbc_lane
   import sbc_pkg::*;
#(
   parameter int TANH_TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lane_ctl_type                   ctl,
   input  cfg_type                        cfg,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0] result
);

   localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);
   localparam int SCL_W = MAG_W + $clog2(TANH_TABLE_DEPTH + 1);
   localparam int CRS_W = SCL_W - TANH_SHIFT;

   logic [SAMPLE_WIDTH-1:0] tanh_rom [TANH_TABLE_DEPTH];

   for (genvar k = 0; k < TANH_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [SAMPLE_WIDTH-1:0] ENTRY = sbc_tanh_entry(k, TANH_TABLE_DEPTH);
      assign tanh_rom[k] = ENTRY;
   end

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [SAMPLE_WIDTH-1:0] drv_ff, drv_in;
   logic signed [SAMPLE_WIDTH-1:0] held_ff, held_in;
   logic signed [SAMPLE_WIDTH-1:0] q_ff, q_in;
   logic signed [BLEND_W-1:0]      dry_ff, dry_in, wet_ff, wet_in;

   // drive multiply
   logic signed [12:0] gain_s;
   assign gain_s  = $signed({1'b0, cfg.drive_gain});
   assign prod_in = PROD_W'(sample * gain_s);

   // tanh shaping
   logic                          prod_neg;
   logic [MAG_W-1:0]              mag;
   logic [SCL_W-1:0]              scaled;
   logic [CRS_W-1:0]              coarse;
   logic                          over;
   logic signed [SAMPLE_WIDTH-1:0] tval;

   always_comb begin
      prod_neg = prod_ff[PROD_W-1];
      mag      = prod_neg ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
      scaled   = SCL_W'(mag) * SCL_W'(TANH_TABLE_DEPTH);
      coarse   = scaled[SCL_W-1:TANH_SHIFT];
      over     = coarse >= CRS_W'(TANH_TABLE_DEPTH);
      tval     = over ? FULL_POS : $signed(tanh_rom[coarse[IDX_W-1:0]]);
      if (cfg.drive_gain <= DRIVE_UNITY) begin
         drv_in = sample_ff;
      end else begin
         drv_in = prod_neg ? -tval : tval;
      end
   end

   // round half up to the step, saturate at positive full scale
   function automatic logic signed [SAMPLE_WIDTH-1:0] quantize(
      input logic signed [SAMPLE_WIDTH-1:0] h,
      input logic [4:0]                     depth
   );
      logic [4:0]              bits;
      logic [3:0]              sh;
      logic [SAMPLE_WIDTH:0]   v;
      logic [SAMPLE_WIDTH:0]   rnd;
      logic [SAMPLE_WIDTH:0]   mask;
      bits = depth;
      if (bits < 5'd1) bits = 5'd1;
      if (bits > 5'(SAMPLE_WIDTH)) bits = 5'(SAMPLE_WIDTH);
      sh   = 4'(5'(SAMPLE_WIDTH) - bits);
      rnd  = (sh == 4'd0) ? '0 : ((SAMPLE_WIDTH+1)'(1) << (sh - 4'd1));
      mask = ~(((SAMPLE_WIDTH+1)'(1) << sh) - (SAMPLE_WIDTH+1)'(1));
      // offset binary so that the mask floors toward minus infinity
      v    = {1'b0, ~h[SAMPLE_WIDTH-1], h[SAMPLE_WIDTH-2:0]} + rnd;
      v    = v & mask;
      if (v[SAMPLE_WIDTH]) return FULL_POS;
      return $signed({~v[SAMPLE_WIDTH-1], v[SAMPLE_WIDTH-2:0]});
   endfunction

   assign held_in = ctl.capture ? drv_ff : held_ff;
   assign q_in    = quantize(held_in, cfg.bit_depth);

   // blend products
   logic [8:0]          mix_c;
   logic signed [9:0]   mix_s, inv_s;
   always_comb begin
      mix_c  = (cfg.mix_amount > MIX_FULL) ? MIX_FULL : cfg.mix_amount;
      mix_s  = $signed({1'b0, mix_c});
      inv_s  = $signed({1'b0, 9'(MIX_FULL - mix_c)});
      dry_in = BLEND_W'(drv_ff * inv_s);
      wet_in = BLEND_W'(q_ff * mix_s);
   end

   // final sum, floor shift and saturation
   logic signed [BLEND_W:0] sum;
   logic signed [BLEND_W:0] shifted;
   always_comb begin
      sum     = (BLEND_W+1)'(dry_ff) + (BLEND_W+1)'(wet_ff) + (BLEND_W+1)'(128);
      shifted = sum >>> 8;
      if (shifted > (BLEND_W+1)'(FULL_POS)) begin
         result = FULL_POS;
      end else if (shifted < (BLEND_W+1)'(FULL_NEG)) begin
         result = FULL_NEG;
      end else begin
         result = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (ctl.quant) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= sample;
         prod_ff   <= prod_in;
      end
      if (ctl.shape) begin
         drv_ff <= drv_in;
      end
      if (ctl.quant) begin
         q_ff <= q_in;
      end
      if (ctl.prod) begin
         dry_ff <= dry_in;
         wet_ff <= wet_in;
      end
   end

endmodule

>>> src/sbc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_merge
// Joins both lane results and the frame flag into the result register.
// ----------------------------------------------------------------------------
module sbc_merge
   import sbc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] left,
   input  logic signed [SAMPLE_WIDTH-1:0] right,
   input  logic                           last,
   output logic                           free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsp_type                        rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // register can take a new item when empty or being drained this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.left_out  <= left;
         data_ff.right_out <= right;
         data_ff.frame_end <= last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> src/stereo_bit_crusher_core.sv
`timescale 1ns / 1ps
// Each item runs the four-step lane sequence (shape, hold/quantize, blend
// products, sum) and rsp_valid rises once the result register takes it; a
// full result register holds the sum step. The next item is taken in the
// final step when the result register is free.
// Reset (synchronous): registers return to defaults, hold count and held
// samples clear, result register empties.
// ----------------------------------------------------------------------------
// stereo_bit_crusher_core
// Stereo bit crusher: tanh drive, sample hold, quantize and dry/wet mix,
// with one lane per channel and a shared sequencer.
// ----------------------------------------------------------------------------
`include "stereo_bit_crusher_core_macros.svh"

module stereo_bit_crusher_core
   import sbc_pkg::*;
#(
   parameter int TANH_TABLE_DEPTH = 256,
   parameter int MAX_HOLD         = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_HOLD + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LUT  = 5'b00010,
      ST_QNT  = 5'b00100,
      ST_PRD  = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]       bit_depth_ff;
   logic [6:0]       hold_interval_ff;
   logic [8:0]       mix_amount_ff;
   logic [11:0]      drive_gain_ff;
   logic [CNT_W-1:0] hold_count_ff, hold_count_in;
   logic             last_ff;

   cfg_type          cfg;
   lane_ctl_type     ctl;
   logic             req_accept;
   logic             out_free;
   logic             out_load;
   logic [6:0]       interval;
   logic             capture;
   logic signed [SAMPLE_WIDTH-1:0] left_res, right_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff     <= RST_BIT_DEPTH;
         hold_interval_ff <= RST_HOLD_INTERVAL;
         mix_amount_ff    <= RST_MIX_AMOUNT;
         drive_gain_ff    <= RST_DRIVE_GAIN;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BIT_DEPTH:     bit_depth_ff     <= csr_wr_data[4:0];
            CSR_HOLD_INTERVAL: hold_interval_ff <= csr_wr_data[6:0];
            CSR_MIX_AMOUNT:    mix_amount_ff    <= csr_wr_data[8:0];
            CSR_DRIVE_GAIN:    drive_gain_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign cfg.bit_depth  = bit_depth_ff;
   assign cfg.mix_amount = mix_amount_ff;
   assign cfg.drive_gain = drive_gain_ff;

   // sequencer
   assign out_load   = (state_ff == ST_SUM) && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) || out_load);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_LUT;
         ST_LUT:  state_in = ST_QNT;
         ST_QNT:  state_in = ST_PRD;
         ST_PRD:  state_in = ST_SUM;
         ST_SUM: begin
            if (out_free) state_in = req_accept ? ST_LUT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold counter, interval clamped to 1..MAX_HOLD
   always_comb begin
      interval = hold_interval_ff;
      if (interval < 7'd1) interval = 7'd1;
      if (interval > 7'(MAX_HOLD)) interval = 7'(MAX_HOLD);
      capture       = 7'(hold_count_ff) >= interval;
      hold_count_in = capture ? '0 : hold_count_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_QNT) begin
            hold_count_ff <= hold_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         last_ff <= req_data.last_frame;
      end
   end

   assign ctl.load    = req_accept;
   assign ctl.shape   = (state_ff == ST_LUT);
   assign ctl.quant   = (state_ff == ST_QNT);
   assign ctl.capture = capture;
   assign ctl.prod    = (state_ff == ST_PRD);

   sbc_lane #(
      .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
   ) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .cfg    (cfg),
      .sample (req_data.left_in),
      .result (left_res)
   );

   sbc_lane #(
      .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
   ) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .cfg    (cfg),
      .sample (req_data.right_in),
      .result (right_res)
   );

   sbc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .left      (left_res),
      .right     (right_res),
      .last      (last_ff),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SBC_ASSERT(a_seq_len, req_accept |-> ##4 (state_ff == ST_SUM), "item did not reach sum step")
   `SBC_ASSERT(a_cnt_bound, hold_count_ff <= CNT_W'(MAX_HOLD), "hold count beyond limit")
   `SBC_ASSERT(a_rsp_src, $rose(rsp_valid) |-> $past(state_ff == ST_SUM), "result without sum step")
   `SBC_ASSERT_NEXT(a_cap_clr, (state_ff == ST_QNT) && capture, hold_count_ff == '0,
                    "hold count not cleared on capture")

endmodule
